// File: src/rating_set_mean_median_mode_assert.svh
// assertion macros used by the checker file
`ifndef RATING_SET_MEAN_MEDIAN_MODE_ASSERT_SVH
`define RATING_SET_MEAN_MEDIAN_MODE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define RSMMM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsmmm check failed");

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define RSMMM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsmmm check failed");

`endif

// File: src/rsmmm_pkg.sv
package rsmmm_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_DRAIN,
		ST_WALK,
		ST_FLUSH,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic sweep;     // read and zero histogram entry at the sweep index
		logic scan;      // the sweep read feeds the median and mode search
		logic init;      // start a new search and a new division
		logic div_step;  // one quotient bit
		logic out_load;  // capture the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic gi_last;   // sweep index sits on the top grade
		logic div_last;  // final quotient bit in this step
	} sts_t;

	localparam logic signed [4:0] NEG_ONE  = -5'sd1;
	localparam int unsigned       SIZE_MAX = 127;

endpackage

// File: src/rsmmm_ram.sv
module rsmmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/rsmmm_ctrl.sv
module rsmmm_ctrl
	import rsmmm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_accept,
	input  logic last,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_stall,
	output logic out_valid
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.gi_last) begin
				state_d = ST_LOAD;
			end
			ST_LOAD: if (in_accept && last) begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_WALK;
			ST_WALK: if (sts.gi_last) begin
				state_d = ST_FLUSH;
			end
			ST_FLUSH: state_d = ST_DIV;
			ST_DIV: if (sts.div_last) begin
				state_d = ST_OUT;
			end
			ST_OUT: if (!out_valid_q || !out_stall) begin
				state_d = ST_LOAD;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.sweep = 1'b1;
			ST_LOAD:  in_stall = 1'b0;
			ST_DRAIN: cmd.init = 1'b1;
			ST_WALK: begin
				cmd.sweep = 1'b1;
				cmd.scan  = 1'b1;
			end
			ST_FLUSH: cmd = '0;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_OUT:   cmd.out_load = !out_valid_q || !out_stall;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/rsmmm_dp.sv
module rsmmm_dp
	import rsmmm_pkg::*;
#(
	parameter int NUM_GRADES = 11,
	parameter int MAX_ITEMS  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              in_accept,
	input  logic [3:0]        rating,
	output logic signed [4:0] mean_value,
	output logic signed [4:0] median_value,
	output logic [3:0]        mode_value,
	output logic [6:0]        set_size,
	output logic              overflow
);

	localparam int GW  = $clog2(NUM_GRADES);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int SW  = CW + GW;
	localparam int DCW = $clog2(SW);
	localparam logic [GW-1:0]  G_LAST = GW'(NUM_GRADES - 1);
	localparam logic [CW-1:0]  C_MAX  = CW'(MAX_ITEMS);
	localparam logic [DCW-1:0] D_TOP  = DCW'(SW - 1);

	// set accumulators
	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_q;
	logic          ovf_q;

	logic          in_range;
	logic          take;
	logic [GW-1:0] grade;

	assign in_range = 32'(rating) < NUM_GRADES;
	assign grade    = GW'(rating);
	assign take     = in_accept && in_range && (count_q != C_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.out_load) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			count_q <= count_q + CW'(1);
			sum_q   <= sum_q + SW'(rating);
		end else if (in_accept && in_range) begin
			ovf_q <= 1'b1;
		end
	end

	// histogram: read on accept, increment in the following cycle
	logic          valid_s1;
	logic [GW-1:0] addr_s1;
	logic          wr_v_q;
	logic [GW-1:0] wr_addr_q;
	logic [CW-1:0] wr_data_q;
	logic [GW-1:0] gi_q;
	logic [CW-1:0] rdata;
	logic [CW-1:0] cnt_old;
	logic [CW-1:0] cnt_inc;
	logic          ram_we;
	logic [GW-1:0] ram_waddr;
	logic [GW-1:0] ram_raddr;
	logic [CW-1:0] ram_wdata;

	// the write of the previous cycle is not yet in the read data
	assign cnt_old   = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : rdata;
	assign cnt_inc   = cnt_old + CW'(1);
	assign ram_we    = valid_s1 || cmd.sweep;
	assign ram_waddr = cmd.sweep ? gi_q : addr_s1;
	assign ram_wdata = cmd.sweep ? '0 : cnt_inc;
	assign ram_raddr = cmd.sweep ? gi_q : grade;

	rsmmm_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_GRADES)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wr_v_q   <= 1'b0;
			gi_q     <= '0;
		end else begin
			valid_s1 <= take;
			wr_v_q   <= valid_s1;
			if (cmd.sweep) begin
				gi_q <= (gi_q == G_LAST) ? '0 : gi_q + GW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= grade;
		wr_addr_q <= addr_s1;
		wr_data_q <= cnt_inc;
	end

	assign sts.gi_last = (gi_q == G_LAST);

	// histogram walk: median positions and mode
	logic          scan_s1;
	logic [GW-1:0] wgrade_s1;
	logic [CW-1:0] acc_q;
	logic [CW-1:0] acc_nxt;
	logic [CW-1:0] pos_hi;
	logic [CW-1:0] pos_lo;
	logic          lo_found_q;
	logic          hi_found_q;
	logic [GW-1:0] lo_q;
	logic [GW-1:0] hi_q;
	logic [CW-1:0] best_q;
	logic [GW-1:0] mode_q;
	logic [GW:0]   med_sum;
	logic [GW-1:0] median_raw;

	assign acc_nxt = acc_q + rdata;
	assign pos_hi  = count_q >> 1;
	assign pos_lo  = pos_hi - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1    <= 1'b0;
			acc_q      <= '0;
			lo_found_q <= 1'b0;
			hi_found_q <= 1'b0;
			best_q     <= '0;
			mode_q     <= '0;
		end else begin
			scan_s1 <= cmd.scan;
			if (cmd.init) begin
				acc_q      <= '0;
				lo_found_q <= 1'b0;
				hi_found_q <= 1'b0;
				best_q     <= '0;
				mode_q     <= '0;
			end else if (scan_s1) begin
				acc_q <= acc_nxt;
				if (!lo_found_q && (pos_lo < acc_nxt)) begin
					lo_found_q <= 1'b1;
				end
				if (!hi_found_q && (pos_hi < acc_nxt)) begin
					hi_found_q <= 1'b1;
				end
				// grade zero never wins, ties keep the smaller grade
				if ((wgrade_s1 != '0) && (rdata > best_q)) begin
					best_q <= rdata;
					mode_q <= wgrade_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wgrade_s1 <= gi_q;
		if (scan_s1 && !lo_found_q && (pos_lo < acc_nxt)) begin
			lo_q <= wgrade_s1;
		end
		if (scan_s1 && !hi_found_q && (pos_hi < acc_nxt)) begin
			hi_q <= wgrade_s1;
		end
	end

	assign med_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign median_raw = count_q[0] ? hi_q : med_sum[GW:1];

	// restoring divider for the mean, one quotient bit per step
	logic [CW-1:0]  rem_q;
	logic [SW-1:0]  quo_q;
	logic [DCW-1:0] dcnt_q;
	logic [CW:0]    trial;
	logic [CW:0]    diff;
	logic           ge;

	assign trial = {rem_q, quo_q[SW-1]};
	assign diff  = trial - {1'b0, count_q};
	assign ge    = trial >= {1'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.init) begin
			dcnt_q <= D_TOP;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			rem_q <= '0;
			quo_q <= sum_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	assign sts.div_last = (dcnt_q == '0);

	// output register
	logic signed [4:0] mean_q;
	logic signed [4:0] median_q;
	logic [3:0]        mode_out_q;
	logic [6:0]        size_q;
	logic              ovf_out_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q     <= (count_q == '0) ? NEG_ONE : $signed(5'(quo_q));
			median_q   <= (count_q == '0) ? NEG_ONE : $signed(5'(median_raw));
			mode_out_q <= 4'(mode_q);
			size_q     <= (32'(count_q) > SIZE_MAX) ? 7'(SIZE_MAX) : 7'(count_q);
			ovf_out_q  <= ovf_q;
		end
	end

	assign mean_value   = mean_q;
	assign median_value = median_q;
	assign mode_value   = mode_out_q;
	assign set_size     = size_q;
	assign overflow     = ovf_out_q;

endmodule

// File: src/rating_set_mean_median_mode.sv
// channel | handshake                      | word
// input   | in_valid / in_stall            | rating, last
// output  | out_valid / out_stall          | mean_value, median_value, mode_value,
//         |                                | set_size, overflow
//
// loading takes one rating per cycle while in_stall is low; the histogram
// read-modify-write is a two-stage path through the ram with a one-deep write bypass
// a word with last set closes the set: drain, histogram walk, flush, divide and
// output load follow, the load waiting while an earlier result is still held,
// before loading resumes
// after reset a clearing pass zeroes every histogram entry, in_stall high
// the walk also zeroes each entry behind it, so the next set starts clean
// a result held by out_stall does not block loading of the next set
module rating_set_mean_median_mode
	import rsmmm_pkg::*;
#(
	parameter int NUM_GRADES = 11,
	parameter int MAX_ITEMS  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        rating,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [4:0] mean_value,
	output logic signed [4:0] median_value,
	output logic [3:0]        mode_value,
	output logic [6:0]        set_size,
	output logic              overflow
);

	cmd_t cmd;
	sts_t sts;
	logic in_accept;

	// a word moves when valid is high and stall is low
	assign in_accept = in_valid && !in_stall;

	// sequencer: clear, load, walk, divide, hand off
	rsmmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.last      (last),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// histogram ram, sum and count, median and mode search, mean divider
	rsmmm_dp #(
		.NUM_GRADES (NUM_GRADES),
		.MAX_ITEMS  (MAX_ITEMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_accept    (in_accept),
		.rating       (rating),
		.mean_value   (mean_value),
		.median_value (median_value),
		.mode_value   (mode_value),
		.set_size     (set_size),
		.overflow     (overflow)
	);

endmodule

// File: src/rsmmm_chk.sv
`include "rating_set_mean_median_mode_assert.svh"

module rsmmm_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              last,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [4:0] mean_value,
	input logic signed [4:0] median_value,
	input logic [3:0]        mode_value,
	input logic [6:0]        set_size,
	input logic              overflow
);

	logic [21:0] result_word;
	logic        empty_marks;

	assign result_word = {mean_value, median_value, mode_value, set_size, overflow};
	assign empty_marks = (mean_value == -5'sd1) && (median_value == -5'sd1) &&
		(mode_value == 4'd0);

	// a held result stays offered
	`RSMMM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

	// a held result keeps its word
	`RSMMM_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(result_word))

	// closing a set stops loading while the result is worked out
	`RSMMM_ASSERT_NXT(a_close_busy, in_valid && !in_stall && last, in_stall)

	// an empty set reports the empty markers
	`RSMMM_ASSERT_IMP(a_empty_set, out_valid && (set_size == 7'd0), empty_marks)

	// a new result appears only out of the busy phase
	`RSMMM_ASSERT_IMP(a_rise_busy, $rose(out_valid), $past(in_stall))

endmodule

bind rating_set_mean_median_mode rsmmm_chk u_chk (.*);

// File: verif/tb_top.sv
module tb_top;
	import rsmmm_pkg::*;

	// block parameters, kept at the defaults of the design
	localparam int unsigned N_GRADES  = 11;
	localparam int unsigned SET_LIMIT = 64;

	// no handshake for this many cycles ends the run
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// bound on waiting for the last results once stimulus is done
	localparam int unsigned DRAIN_LIMIT = 4000;
	// accepted words after which the random sets stop
	localparam int unsigned LOAD_TARGET = 850;

	// one result word as the block reports it
	typedef struct packed {
		logic signed [4:0] mean;
		logic signed [4:0] median;
		logic [3:0]        mode;
		logic [6:0]        size;
		logic              ovf;
	} set_stats_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [3:0]        rating = 4'd0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [4:0] mean_value;
	logic signed [4:0] median_value;
	logic [3:0]        mode_value;
	logic [6:0]        set_size;
	logic              overflow;

	// predicted state of the set being loaded
	int unsigned grade_hist [N_GRADES];
	int unsigned rating_sum = 0;
	int unsigned rating_cnt = 0;
	bit          ovf_seen = 1'b0;

	// results still owed by the block, oldest first
	set_stats_t  stats_due [$];

	int unsigned fail_count = 0;
	int unsigned loaded_cnt = 0;

	// idling knobs, percent of words preceded by a gap
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// long receiver hold-off, picked up by the receiver process
	int unsigned hold_cycles = 0;

	rating_set_mean_median_mode #(
		.NUM_GRADES(N_GRADES),
		.MAX_ITEMS (SET_LIMIT)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rating      (rating),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mean_value  (mean_value),
		.median_value(median_value),
		.mode_value  (mode_value),
		.set_size    (set_size),
		.overflow    (overflow)
	);

	// 8 unit period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// gap length: mostly none, some short, a few long
	function automatic int unsigned idle_len(int unsigned pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) != 0)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// rating found at a given rank of the sorted set, walking the histogram upward
	function automatic int unsigned rating_at_rank(int unsigned rank);
		int unsigned acc;
		acc = 0;
		for (int unsigned g = 0; g < N_GRADES; g++) begin
			acc += grade_hist[g];
			if (rank < acc)
				return g;
		end
		return N_GRADES - 1;
	endfunction

	// fold one accepted word into the set; a closing word yields the expected stats
	task automatic tally_rating(input logic [3:0] r, input logic l);
		set_stats_t  s;
		int unsigned best;
		int unsigned n;
		loaded_cnt++;
		// out-of-range ratings leave the set untouched
		if (r < N_GRADES) begin
			if (rating_cnt >= SET_LIMIT) begin
				// set already full: word is dropped, flag sticks until the set closes
				ovf_seen = 1'b1;
			end else begin
				grade_hist[r]++;
				rating_sum += r;
				rating_cnt++;
			end
		end
		if (!l)
			return;
		n = rating_cnt;
		if (n == 0) begin
			// empty set
			s.mean   = NEG_ONE;
			s.median = NEG_ONE;
		end else begin
			s.mean = 5'(rating_sum / n);
			// even count: truncated average of the two middle ratings
			if (n % 2 == 0)
				s.median = 5'((rating_at_rank(n / 2 - 1) + rating_at_rank(n / 2)) / 2);
			else
				s.median = 5'(rating_at_rank(n / 2));
		end
		// mode: lowest rating 1 and up with the highest count; zero never wins
		s.mode = 4'd0;
		best   = 0;
		for (int unsigned g = 1; g < N_GRADES; g++) begin
			if (grade_hist[g] > best) begin
				best   = grade_hist[g];
				s.mode = 4'(g);
			end
		end
		s.size = 7'((n > SIZE_MAX) ? SIZE_MAX : n);
		s.ovf  = ovf_seen;
		stats_due.push_back(s);
		// the set closes, state starts over
		foreach (grade_hist[g])
			grade_hist[g] = 0;
		rating_sum = 0;
		rating_cnt = 0;
		ovf_seen   = 1'b0;
	endtask

	// offer one word; entered and left at a falling edge, valid stays up for a
	// back-to-back word
	task automatic send_word(input logic [3:0] r, input logic l);
		int unsigned gap;
		gap = idle_len(send_idle_pct);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rating   <= r;
		last     <= l;
		do
			@(posedge clk);
		while (in_stall);
		tally_rating(r, l);
		@(negedge clk);
	endtask

	// receiver: random stall stretches, or a long hold-off when asked
	always begin : receiver
		int unsigned hold;
		@(negedge clk);
		if (hold_cycles != 0) begin
			hold        = hold_cycles;
			hold_cycles = 0;
		end else begin
			hold = idle_len(recv_idle_pct);
		end
		if (hold != 0) begin
			out_stall <= 1'b1;
			repeat (hold) @(negedge clk);
		end
		out_stall <= 1'b0;
	end

	// compare every accepted result word against the oldest prediction
	always @(posedge clk) begin : result_check
		set_stats_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (stats_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: mean %0d median %0d mode %0d size %0d ovf %0b",
						mean_value, median_value, mode_value, set_size, overflow);
			end else begin
				want = stats_due.pop_front();
				if (mean_value !== want.mean || median_value !== want.median ||
						mode_value !== want.mode || set_size !== want.size ||
						overflow !== want.ovf) begin
					fail_count++;
					if (fail_count <= 10) begin
						$write("mismatch (expected/actual): mean %0d/%0d median %0d/%0d ",
							want.mean, mean_value, want.median, median_value);
						$display("mode %0d/%0d size %0d/%0d ovf %0b/%0b",
							want.mode, mode_value, want.size, set_size,
							want.ovf, overflow);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL");
		$finish;
	end

	// hand-picked sets: extremes, ties, even and odd counts, empty sets
	task automatic test_directed();
		send_idle_pct = 20;
		recv_idle_pct = 20;
		// single rating
		send_word(4'd5, 1'b1);
		// only zero: mean and median zero, no mode
		send_word(4'd0, 1'b1);
		// even count with the two extremes, rating 10 is the mode
		send_word(4'd10, 1'b0);
		send_word(4'd0, 1'b1);
		// closing word out of range and nothing counted: empty set
		send_word(4'd15, 1'b1);
		// out-of-range word mid set is skipped; tie resolves to the lower rating
		send_word(4'd3, 1'b0);
		send_word(4'd14, 1'b0);
		send_word(4'd7, 1'b1);
		// two-way tie on the mode, even median
		send_word(4'd2, 1'b0);
		send_word(4'd9, 1'b0);
		send_word(4'd9, 1'b0);
		send_word(4'd2, 1'b1);
		// odd count, truncated mean
		send_word(4'd1, 1'b0);
		send_word(4'd4, 1'b0);
		send_word(4'd8, 1'b1);
		// two out-of-range words only
		send_word(4'd13, 1'b0);
		send_word(4'd11, 1'b1);
		// top rating dominates
		send_word(4'd10, 1'b0);
		send_word(4'd10, 1'b0);
		send_word(4'd6, 1'b1);
	endtask

	// sets at and beyond the item limit
	task automatic test_set_limit();
		send_idle_pct = 10;
		recv_idle_pct = 10;
		// exactly full with the top rating: largest sum
		for (int unsigned k = 0; k < SET_LIMIT; k++)
			send_word(4'd10, k == SET_LIMIT - 1);
		// exactly full, random ratings
		for (int unsigned k = 0; k < SET_LIMIT; k++)
			send_word(4'($urandom_range(N_GRADES - 1)), k == SET_LIMIT - 1);
		// one past full: the closing word itself is dropped
		for (int unsigned k = 0; k <= SET_LIMIT; k++)
			send_word(4'($urandom_range(N_GRADES - 1)), k == SET_LIMIT);
		// well past full, closed by an out-of-range word
		for (int unsigned k = 0; k < SET_LIMIT + 5; k++)
			send_word(4'($urandom_range(N_GRADES - 1)), 1'b0);
		send_word(4'd12, 1'b1);
	endtask

	// receiver holds off for a long stretch while small sets keep coming, so
	// the output register fills and the block has to stall its input
	task automatic test_output_hold();
		int unsigned len;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles   = 300;
		for (int unsigned k = 0; k < 12; k++) begin
			len = $urandom_range(4, 1);
			for (int unsigned j = 0; j < len; j++)
				send_word(4'($urandom_range(N_GRADES - 1)), j == len - 1);
		end
	endtask

	// random sets: mostly short, some long, a few at or over the limit
	task automatic test_random_sets();
		int unsigned pick;
		int unsigned len;
		int unsigned lo;
		int unsigned span;
		int unsigned noise_pct;
		logic [3:0]  r;
		while (loaded_cnt < LOAD_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 4)
				len = $urandom_range(SET_LIMIT + 16, SET_LIMIT + 1);
			else if (pick < 10)
				len = $urandom_range(SET_LIMIT, SET_LIMIT - 8);
			else if (pick < 30)
				len = $urandom_range(40, 13);
			else
				len = $urandom_range(12, 1);
			// narrow ratings spread makes ties and repeated medians likely
			lo   = $urandom_range(N_GRADES - 1);
			span = $urandom_range(1) ? N_GRADES : 3;
			// occasional set of nothing but out-of-range words
			noise_pct = ($urandom_range(19) == 0) ? 100 : 8;
			// idling on or off per set, so quiet stretches also occur
			send_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
			recv_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
			for (int unsigned k = 0; k < len; k++) begin
				if ($urandom_range(99) < noise_pct)
					r = 4'($urandom_range(15, N_GRADES));
				else
					r = 4'((lo + $urandom_range(span - 1)) % N_GRADES);
				send_word(r, k == len - 1);
			end
		end
	endtask

	initial begin : main
		int unsigned waited;
		foreach (grade_hist[g])
			grade_hist[g] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_set_limit();
		test_output_hold();
		test_random_sets();
		in_valid <= 1'b0;

		// let the outstanding results drain, then a little extra for strays
		waited = 0;
		while (stats_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (stats_due.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", stats_due.size());
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
